// File: rtl/arcbus_pkg.sv
// arcbus_pkg: shared types and constants for the arcade bus decoder
// holds access codes, region codes, port numbers, item/result/state structs
// no dependencies
`default_nettype none

package arcbus_pkg;

  // bus access kinds carried in s_tuser
  typedef enum logic [2:0] {
    FUNC_MAIN_RD  = 3'd0,
    FUNC_MAIN_WR  = 3'd1,
    FUNC_MAIN_FE  = 3'd2,
    FUNC_IO_IN    = 3'd3,
    FUNC_IO_OUT   = 3'd4,
    FUNC_SND_RD   = 3'd5,
    FUNC_SND_WR   = 3'd6
  } func_t;

  // memory regions carried in m_tuser
  typedef enum logic [3:0] {
    REG_NONE        = 4'd0,
    REG_OPCODE_ROM  = 4'd1,
    REG_DATA_ROM    = 4'd2,
    REG_RAM         = 4'd3,
    REG_SPRITE      = 4'd4,
    REG_PALETTE     = 4'd5,
    REG_VIDEO       = 4'd6,
    REG_MIX_COLL    = 4'd7,
    REG_MIX_SUM     = 4'd8,
    REG_SPR_COLL    = 4'd9,
    REG_SPR_SUM     = 4'd10,
    REG_SND_ROM     = 4'd11,
    REG_SND_RAM     = 4'd12,
    REG_SND_CHIP_A  = 4'd13,
    REG_SND_CHIP_B  = 4'd14
  } region_t;

  // i/o port numbers (low five address bits)
  localparam logic [4:0] PORT_PLAYER_ONE = 5'h00;
  localparam logic [4:0] PORT_PLAYER_TWO = 5'h04;
  localparam logic [4:0] PORT_SYSTEM     = 5'h08;
  localparam logic [4:0] PORT_DSW_A_LO   = 5'h0C;
  localparam logic [4:0] PORT_DSW_B_LO   = 5'h0D;
  localparam logic [4:0] PORT_DSW_A_HI   = 5'h0E;
  localparam logic [4:0] PORT_DSW_B_HI   = 5'h0F;
  localparam logic [4:0] PORT_DSW_B_X0   = 5'h10;
  localparam logic [4:0] PORT_DSW_B_X1   = 5'h11;
  localparam logic [4:0] PORT_DSW_B_X2   = 5'h12;
  localparam logic [4:0] PORT_DSW_B_X3   = 5'h13;
  localparam logic [4:0] PORT_SOUND_CMD  = 5'h14;
  localparam logic [4:0] PORT_MODE       = 5'h15;
  localparam logic [4:0] PORT_C          = 5'h16;
  localparam logic [4:0] PORT_CONTROL    = 5'h17;

  // configuration register indexes (paddr bit 2)
  localparam logic CFG_DSW_A = 1'b0;
  localparam logic CFG_DSW_B = 1'b1;

  // misc constants
  localparam logic [7:0] UNMAPPED_BYTE  = 8'hFF;
  localparam logic [7:0] MERGE_BASE     = 8'h7E;
  localparam logic [2:0] SND_LATCH_SEL  = 3'b111;
  localparam logic [2:0] SND_CHIP_A_SEL = 3'b101;
  localparam logic [2:0] SND_CHIP_B_SEL = 3'b110;
  localparam int         PORTC_ACK_BIT  = 6;

  // one bus access
  typedef struct packed {
    func_t       func;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  player_one;
    logic [7:0]  player_two;
    logic [7:0]  system_buttons;
    logic        mix_flag;
    logic        sprite_flag;
  } item_t;

  // decode answer for one access
  typedef struct packed {
    region_t     region;
    logic [16:0] offset;
    logic        write_strobe;
    logic [7:0]  wr_byte;
    logic        direct_valid;
    logic [7:0]  direct_data;
    logic [7:0]  merge_mask;
    logic        sound_nmi;
    logic        flip_screen;
  } result_t;

  // latches of the parallel port chip
  typedef struct packed {
    logic [1:0] rom_bank;
    logic [7:0] disp_mode;
    logic [7:0] port_c;
    logic [7:0] video_bank;
    logic [7:0] sound_command;
  } ppi_state_t;

endpackage

`default_nettype wire

// File: rtl/arcbus_decode.sv
// arcbus_decode: combinational address decode and port latch update
// maps one access plus current latches to a result and the next latches
// depends on arcbus_pkg
`default_nettype none

module arcbus_decode import arcbus_pkg::*; #(
  parameter int VIDEO_RAM_BYTES = 16384
) (
  input  item_t      item,
  input  ppi_state_t state,
  input  logic [7:0] dip_switch_a,
  input  logic [7:0] dip_switch_b,
  output result_t    res,
  output ppi_state_t state_next
);

  localparam logic [13:0] VID_MASK = 14'(VIDEO_RAM_BYTES - 1);

  logic [15:0] a;
  logic [7:0]  v;
  logic [16:0] banked_off;
  logic [13:0] vid_off;
  logic [7:0]  pc_upd;
  result_t     rd;

  assign a          = item.addr;
  assign v          = item.wdata;
  assign banked_off = {1'b1, state.rom_bank, a[13:0]};
  assign vid_off    = {state.video_bank[2:1], a[11:0]} & VID_MASK;

  // port c with one bit set or cleared by the control command
  always_comb begin
    pc_upd = state.port_c;
    pc_upd[v[3:1]] = v[0];
  end

  // main processor read map, also used by fetches above rom
  always_comb begin
    rd = '0;
    priority if (a < 16'h8000) begin
      rd.region = REG_DATA_ROM;
      rd.offset = {1'b0, a};
    end else if (a < 16'hC000) begin
      rd.region = REG_DATA_ROM;
      rd.offset = banked_off;
    end else if (a < 16'hD000) begin
      rd.region = REG_RAM;
      rd.offset = {5'b0, a[11:0]};
    end else if (a < 16'hD800) begin
      rd.region = REG_SPRITE;
      rd.offset = {6'b0, a[10:0]};
    end else if (a < 16'hE000) begin
      rd.region = REG_PALETTE;
      rd.offset = {6'b0, a[10:0]};
    end else if (a < 16'hF000) begin
      rd.region = REG_VIDEO;
      rd.offset = {3'b0, vid_off};
    end else if (a < 16'hF400) begin
      rd.region     = REG_MIX_COLL;
      rd.offset     = {11'b0, a[5:0]};
      rd.merge_mask = MERGE_BASE | {item.mix_flag, 7'b0};
    end else if (a < 16'hF800) begin
      rd.direct_valid = 1'b1;
      rd.direct_data  = UNMAPPED_BYTE;
    end else if (a < 16'hFC00) begin
      rd.region     = REG_SPR_COLL;
      rd.offset     = {7'b0, a[9:0]};
      rd.merge_mask = MERGE_BASE | {item.sprite_flag, 7'b0};
    end else begin
      rd.direct_valid = 1'b1;
      rd.direct_data  = UNMAPPED_BYTE;
    end
  end

  // per access kind decode and latch update
  always_comb begin
    res        = '0;
    state_next = state;
    unique case (item.func)
      FUNC_MAIN_RD: begin
        res = rd;
      end
      FUNC_MAIN_WR: begin
        if (a >= 16'hC000) begin
          res.write_strobe = 1'b1;
          priority if (a < 16'hD000) begin
            res.region  = REG_RAM;
            res.offset  = {5'b0, a[11:0]};
            res.wr_byte = v;
          end else if (a < 16'hD800) begin
            res.region  = REG_SPRITE;
            res.offset  = {6'b0, a[10:0]};
            res.wr_byte = v;
          end else if (a < 16'hE000) begin
            res.region  = REG_PALETTE;
            res.offset  = {6'b0, a[10:0]};
            res.wr_byte = v;
          end else if (a < 16'hF000) begin
            res.region  = REG_VIDEO;
            res.offset  = {3'b0, vid_off};
            res.wr_byte = v;
          end else if (a < 16'hF400) begin
            res.region = REG_MIX_COLL;
            res.offset = {11'b0, a[5:0]};
          end else if (a < 16'hF800) begin
            res.region = REG_MIX_SUM;
          end else if (a < 16'hFC00) begin
            res.region = REG_SPR_COLL;
            res.offset = {7'b0, a[9:0]};
          end else begin
            res.region = REG_SPR_SUM;
          end
        end
      end
      FUNC_MAIN_FE: begin
        priority if (a < 16'h8000) begin
          res.region = REG_OPCODE_ROM;
          res.offset = {1'b0, a};
        end else if (a < 16'hC000) begin
          res.region = REG_OPCODE_ROM;
          res.offset = banked_off;
        end else begin
          res = rd;
        end
      end
      FUNC_IO_IN: begin
        res.direct_valid = 1'b1;
        unique case (a[4:0])
          PORT_PLAYER_ONE: res.direct_data = ~item.player_one;
          PORT_PLAYER_TWO: res.direct_data = ~item.player_two;
          PORT_SYSTEM:     res.direct_data = ~item.system_buttons;
          PORT_DSW_A_LO, PORT_DSW_A_HI: res.direct_data = dip_switch_a;
          PORT_DSW_B_LO, PORT_DSW_B_HI, PORT_DSW_B_X0, PORT_DSW_B_X1,
          PORT_DSW_B_X2, PORT_DSW_B_X3: res.direct_data = dip_switch_b;
          PORT_SOUND_CMD:  res.direct_data = state.sound_command;
          PORT_MODE:       res.direct_data = state.disp_mode;
          PORT_C:          res.direct_data = state.port_c;
          default:         res.direct_data = UNMAPPED_BYTE;
        endcase
      end
      FUNC_IO_OUT: begin
        unique case (a[4:0])
          PORT_SOUND_CMD: begin
            state_next.sound_command = v;
            res.sound_nmi            = 1'b1;
          end
          PORT_MODE: begin
            state_next.rom_bank  = v[3:2];
            state_next.disp_mode = v;
          end
          PORT_C: begin
            state_next.port_c     = v;
            state_next.video_bank = v;
          end
          PORT_CONTROL: begin
            // bit 7 set is a mode set, which is ignored
            if (!v[7]) begin
              state_next.port_c     = pc_upd;
              state_next.video_bank = pc_upd;
            end
          end
          default: ;
        endcase
      end
      FUNC_SND_RD: begin
        priority if (a < 16'h8000) begin
          res.region = REG_SND_ROM;
          res.offset = {1'b0, a};
        end else if (a < 16'h8800) begin
          res.region = REG_SND_RAM;
          res.offset = {6'b0, a[10:0]};
        end else if (a[15:13] == SND_LATCH_SEL) begin
          // latch read acknowledges on port c only
          state_next.port_c[PORTC_ACK_BIT] = 1'b1;
          res.direct_valid = 1'b1;
          res.direct_data  = state.sound_command;
        end else begin
          res.direct_valid = 1'b1;
          res.direct_data  = UNMAPPED_BYTE;
        end
      end
      FUNC_SND_WR: begin
        priority if (a >= 16'h8000 && a < 16'h8800) begin
          res.region       = REG_SND_RAM;
          res.offset       = {6'b0, a[10:0]};
          res.write_strobe = 1'b1;
          res.wr_byte      = v;
        end else if (a[15:13] == SND_CHIP_A_SEL) begin
          res.region       = REG_SND_CHIP_A;
          res.write_strobe = 1'b1;
          res.wr_byte      = v;
        end else if (a[15:13] == SND_CHIP_B_SEL) begin
          res.region       = REG_SND_CHIP_B;
          res.write_strobe = 1'b1;
          res.wr_byte      = v;
        end else begin
          res = '0;
        end
      end
      default: ;
    endcase
    // flip follows the mode register after this access
    res.flip_screen = state_next.disp_mode[7];
  end

endmodule

`default_nettype wire

// File: rtl/arcade_bus_decoder_ppi.sv
// Bus decoder with parallel-port latches for a two-processor arcade board.
// Each accepted access (kind on s_tuser, address, write byte, controls and
// collision flags on s_tdata) gives one result: region on m_tuser, offset,
// write strobe and byte, direct read data, collision merge mask, sound NMI
// pulse and flip bit on m_tdata. The path is an input register, one level of
// decode logic and a result register; one access is taken every cycle as long
// as results are taken on m_tready. The latches (ROM bank, video mode, port C,
// video bank, sound command) change as an access passes the decode stage, so
// each access sees the effect of all earlier ones. An access is still taken
// while a finished result waits on m_tready; the input stalls only when both
// stages are full. DIP switch banks A and B sit at APB byte addresses 0x0 and
// 0x4 and reset to 0xFF.
// depends on arcbus_pkg and arcbus_decode
`default_nettype none

module arcade_bus_decoder_ppi import arcbus_pkg::*; #(
  parameter int VIDEO_RAM_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  // access stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // addr[15:0], wdata[23:16], player_one[31:24], player_two[39:32],
  // system_buttons[47:40], mix_flag[48], sprite_flag[49], zero[55:50]
  input  logic [55:0] s_tdata,
  // func[2:0]
  input  logic [2:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // offset[16:0], write_strobe[17], wr_byte[25:18], direct_valid[26],
  // direct_data[34:27], merge_mask[42:35], sound_nmi[43], flip_screen[44],
  // zero[47:45]
  output logic [47:0] m_tdata,
  // region[3:0]
  output logic [3:0]  m_tuser,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] dip_switch_a;
  logic [7:0] dip_switch_b;
  logic       cfg_wr;

  ppi_state_t state;
  ppi_state_t state_next;

  logic    in_valid;
  item_t   in_item;
  logic    adv;
  logic    s_fire;
  result_t res_next;
  result_t res;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {24'b0, (paddr[2] == CFG_DSW_B) ? dip_switch_b : dip_switch_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      dip_switch_a <= UNMAPPED_BYTE;
      dip_switch_b <= UNMAPPED_BYTE;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_DSW_A) dip_switch_a <= pwdata[7:0];
      else                       dip_switch_b <= pwdata[7:0];
    end
  end

  // pipeline handshake
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;
  assign s_fire   = s_tvalid && s_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_item.func           <= func_t'(s_tuser);
      in_item.addr           <= s_tdata[15:0];
      in_item.wdata          <= s_tdata[23:16];
      in_item.player_one     <= s_tdata[31:24];
      in_item.player_two     <= s_tdata[39:32];
      in_item.system_buttons <= s_tdata[47:40];
      in_item.mix_flag       <= s_tdata[48];
      in_item.sprite_flag    <= s_tdata[49];
    end
  end

  // decode stage
  arcbus_decode #(
    .VIDEO_RAM_BYTES(VIDEO_RAM_BYTES)
  ) u_decode (
    .item        (in_item),
    .state       (state),
    .dip_switch_a(dip_switch_a),
    .dip_switch_b(dip_switch_b),
    .res         (res_next),
    .state_next  (state_next)
  );

  // port latches move with the access that passes decode
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (adv) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

  assign m_tuser = res.region;
  assign m_tdata = {3'b0, res.flip_screen, res.sound_nmi, res.merge_mask,
                    res.direct_data, res.direct_valid, res.wr_byte,
                    res.write_strobe, res.offset};

  // a held access moves to an empty result stage in the next cycle
  a_drain: assert property (@(posedge clk) disable iff (rst)
    in_valid && !m_tvalid |=> m_tvalid)
    else $error("decoded access did not reach the result stage");

  // a strobe always names a region
  a_strobe_region: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.write_strobe |-> res.region != REG_NONE)
    else $error("write strobe without a region");

  // direct data never comes with a memory region or merge mask
  a_direct_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.direct_valid |-> res.region == REG_NONE && res.merge_mask == 8'h00)
    else $error("direct data mixed with a memory answer");

  // a sound nmi leaves the written byte in the command latch
  a_nmi_latch: assert property (@(posedge clk) disable iff (rst)
    adv && res_next.sound_nmi |=> state.sound_command == $past(in_item.wdata))
    else $error("sound command latch not updated with nmi");

endmodule

`default_nettype wire

// File: tb/bus_decode_board_pkg.sv
// bus_decode_board_pkg: predictor and result store for the arcade bus decoder
// keeps its own copy of the port latches and dip switches; depends on arcbus_pkg
`default_nettype none

package bus_decode_board_pkg;
  import arcbus_pkg::*;

  class bus_decode_board;
    // latches and switches as the predictor sees them
    logic [1:0]  rom_bank;
    logic [7:0]  disp_mode;
    logic [7:0]  port_c;
    logic [7:0]  video_bank;
    logic [7:0]  sound_cmd;
    logic [7:0]  dsw_a;
    logic [7:0]  dsw_b;
    int          vram_bytes;
    result_t     pending_decodes[$];
    int          errors;
    int          results_seen;

    function new(int vram);
      vram_bytes = vram;
      rom_bank   = '0;
      disp_mode  = '0;
      port_c     = '0;
      video_bank = '0;
      sound_cmd  = '0;
      dsw_a      = 8'hFF;
      dsw_b      = 8'hFF;
      errors     = 0;
      results_seen = 0;
    endfunction

    function void set_switch(logic idx, logic [7:0] val);
      if (idx == CFG_DSW_A) dsw_a = val;
      else dsw_b = val;
    endfunction

    // 16 KiB rom pages above 0x8000
    function logic [16:0] banked_rom(logic [15:0] a);
      return 17'h10000 + {1'b0, rom_bank, 14'h0} + 17'(a - 16'h8000);
    endfunction

    // 4 KiB video pages selected by video bank bits 2:1
    function logic [16:0] video_offset(logic [15:0] a);
      return {3'b0, video_bank[2:1], a[11:0]} & 17'(vram_bytes - 1);
    endfunction

    function result_t strobe(region_t g, logic [16:0] off, logic [7:0] val);
      result_t r;
      r = '0;
      r.region = g;
      r.offset = off;
      r.write_strobe = 1'b1;
      r.wr_byte = val;
      return r;
    endfunction

    function result_t cpu_rd_map(logic [15:0] a, logic mix, logic spr);
      result_t r;
      r = '0;
      if (a < 16'h8000) begin
        r.region = REG_DATA_ROM;
        r.offset = {1'b0, a};
      end else if (a < 16'hC000) begin
        r.region = REG_DATA_ROM;
        r.offset = banked_rom(a);
      end else if (a < 16'hD000) begin
        r.region = REG_RAM;
        r.offset = 17'(a - 16'hC000);
      end else if (a < 16'hD800) begin
        r.region = REG_SPRITE;
        r.offset = 17'(a - 16'hD000);
      end else if (a < 16'hE000) begin
        r.region = REG_PALETTE;
        r.offset = 17'(a - 16'hD800);
      end else if (a < 16'hF000) begin
        r.region = REG_VIDEO;
        r.offset = video_offset(a);
      end else if (a < 16'hF400) begin
        r.region = REG_MIX_COLL;
        r.offset = 17'(a[5:0]);
        r.merge_mask = MERGE_BASE | {mix, 7'b0};
      end else if (a >= 16'hF800 && a < 16'hFC00) begin
        r.region = REG_SPR_COLL;
        r.offset = 17'(a[9:0]);
        r.merge_mask = MERGE_BASE | {spr, 7'b0};
      end else begin
        // collision reset space reads back as unmapped
        r.direct_valid = 1'b1;
        r.direct_data = UNMAPPED_BYTE;
      end
      return r;
    endfunction

    // expected result of one access, with its effect on the latches
    function result_t decode_access(item_t it);
      result_t r;
      logic [15:0] a;
      logic [7:0] v;
      logic [7:0] pc;
      a = it.addr;
      v = it.wdata;
      r = '0;
      case (it.func)
        FUNC_MAIN_RD: r = cpu_rd_map(a, it.mix_flag, it.sprite_flag);
        FUNC_MAIN_WR: begin
          if (a < 16'hC000) r = '0;
          else if (a < 16'hD000) r = strobe(REG_RAM, 17'(a - 16'hC000), v);
          else if (a < 16'hD800) r = strobe(REG_SPRITE, 17'(a - 16'hD000), v);
          else if (a < 16'hE000) r = strobe(REG_PALETTE, 17'(a - 16'hD800), v);
          else if (a < 16'hF000) r = strobe(REG_VIDEO, video_offset(a), v);
          else if (a < 16'hF400) r = strobe(REG_MIX_COLL, 17'(a[5:0]), 8'h00);
          else if (a < 16'hF800) r = strobe(REG_MIX_SUM, 17'h0, 8'h00);
          else if (a < 16'hFC00) r = strobe(REG_SPR_COLL, 17'(a[9:0]), 8'h00);
          else r = strobe(REG_SPR_SUM, 17'h0, 8'h00);
        end
        FUNC_MAIN_FE: begin
          if (a < 16'h8000) begin
            r.region = REG_OPCODE_ROM;
            r.offset = {1'b0, a};
          end else if (a < 16'hC000) begin
            r.region = REG_OPCODE_ROM;
            r.offset = banked_rom(a);
          end else begin
            r = cpu_rd_map(a, it.mix_flag, it.sprite_flag);
          end
        end
        FUNC_IO_IN: begin
          r.direct_valid = 1'b1;
          case (a[4:0])
            PORT_PLAYER_ONE: r.direct_data = ~it.player_one;
            PORT_PLAYER_TWO: r.direct_data = ~it.player_two;
            PORT_SYSTEM:     r.direct_data = ~it.system_buttons;
            PORT_DSW_A_LO, PORT_DSW_A_HI: r.direct_data = dsw_a;
            PORT_DSW_B_LO, PORT_DSW_B_HI, PORT_DSW_B_X0, PORT_DSW_B_X1,
            PORT_DSW_B_X2, PORT_DSW_B_X3: r.direct_data = dsw_b;
            PORT_SOUND_CMD:  r.direct_data = sound_cmd;
            PORT_MODE:       r.direct_data = disp_mode;
            PORT_C:          r.direct_data = port_c;
            default:         r.direct_data = UNMAPPED_BYTE;
          endcase
        end
        FUNC_IO_OUT: begin
          case (a[4:0])
            PORT_SOUND_CMD: begin
              sound_cmd = v;
              r.sound_nmi = 1'b1;
            end
            PORT_MODE: begin
              rom_bank = v[3:2];
              disp_mode = v;
            end
            PORT_C: begin
              port_c = v;
              video_bank = v;
            end
            PORT_CONTROL: begin
              // bit set/reset; mode set commands are ignored
              if (!v[7]) begin
                pc = port_c;
                pc[v[3:1]] = v[0];
                port_c = pc;
                video_bank = pc;
              end
            end
            default: ;
          endcase
        end
        FUNC_SND_RD: begin
          if (a < 16'h8000) begin
            r.region = REG_SND_ROM;
            r.offset = {1'b0, a};
          end else if (a < 16'h8800) begin
            r.region = REG_SND_RAM;
            r.offset = 17'(a - 16'h8000);
          end else if (a[15:13] == SND_LATCH_SEL) begin
            // latch read acks on port c only, video bank untouched
            port_c[PORTC_ACK_BIT] = 1'b1;
            r.direct_valid = 1'b1;
            r.direct_data = sound_cmd;
          end else begin
            r.direct_valid = 1'b1;
            r.direct_data = UNMAPPED_BYTE;
          end
        end
        FUNC_SND_WR: begin
          if (a >= 16'h8000 && a < 16'h8800) r = strobe(REG_SND_RAM, 17'(a - 16'h8000), v);
          else if (a[15:13] == SND_CHIP_A_SEL) r = strobe(REG_SND_CHIP_A, 17'h0, v);
          else if (a[15:13] == SND_CHIP_B_SEL) r = strobe(REG_SND_CHIP_B, 17'h0, v);
        end
        default: ;
      endcase
      r.flip_screen = disp_mode[7];
      return r;
    endfunction

    function void note_access(item_t it);
      pending_decodes.push_back(decode_access(it));
    endfunction

    task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("result %0d: %s got %0h, expected %0h", results_seen, what, got, want);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      results_seen++;
      if (pending_decodes.size() == 0) begin
        flag_mismatch("unexpected result, region", 32'(got.region), 32'(REG_NONE));
      end else begin
        want = pending_decodes.pop_front();
        if (got.region !== want.region)
          flag_mismatch("region", 32'(got.region), 32'(want.region));
        if (got.offset !== want.offset)
          flag_mismatch("offset", 32'(got.offset), 32'(want.offset));
        if (got.write_strobe !== want.write_strobe)
          flag_mismatch("write_strobe", 32'(got.write_strobe), 32'(want.write_strobe));
        if (got.wr_byte !== want.wr_byte)
          flag_mismatch("wr_byte", 32'(got.wr_byte), 32'(want.wr_byte));
        if (got.direct_valid !== want.direct_valid)
          flag_mismatch("direct_valid", 32'(got.direct_valid), 32'(want.direct_valid));
        if (got.direct_data !== want.direct_data)
          flag_mismatch("direct_data", 32'(got.direct_data), 32'(want.direct_data));
        if (got.merge_mask !== want.merge_mask)
          flag_mismatch("merge_mask", 32'(got.merge_mask), 32'(want.merge_mask));
        if (got.sound_nmi !== want.sound_nmi)
          flag_mismatch("sound_nmi", 32'(got.sound_nmi), 32'(want.sound_nmi));
        if (got.flip_screen !== want.flip_screen)
          flag_mismatch("flip_screen", 32'(got.flip_screen), 32'(want.flip_screen));
      end
    endtask
  endclass

endpackage

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: drives bus accesses and dip switch writes into arcade_bus_decoder_ppi
// and checks every decode against bus_decode_board; depends on arcbus_pkg
// and bus_decode_board_pkg
`default_nettype none

module tb_top;
  import arcbus_pkg::*;
  import bus_decode_board_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VRAM_BYTES = 16384;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 400;
  localparam logic [2:0] FUNC_UNDEFINED = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bus_decode_board board;
  bit          calm = 1'b0;
  int          cycles = 0;

  arcade_bus_decoder_ppi #(.VIDEO_RAM_BYTES(VRAM_BYTES)) i_dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 30);
  end

  // result monitor
  always @(posedge clk) begin : result_mon
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.region       = region_t'(m_tuser);
      got.offset       = m_tdata[16:0];
      got.write_strobe = m_tdata[17];
      got.wr_byte      = m_tdata[25:18];
      got.direct_valid = m_tdata[26];
      got.direct_data  = m_tdata[34:27];
      got.merge_mask   = m_tdata[42:35];
      got.sound_nmi    = m_tdata[43];
      got.flip_screen  = m_tdata[44];
      board.check_result(got);
    end
  end

  // one item on the access stream, with an optional idle gap first
  task automatic send(item_t it);
    int gap;
    gap = (!calm && $urandom_range(99) < 22) ? $urandom_range(3, 1) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.func;
    s_tdata  <= {6'b0, it.sprite_flag, it.mix_flag, it.system_buttons,
                 it.player_two, it.player_one, it.wdata, it.addr};
    do @(posedge clk); while (!s_tready);
    board.note_access(it);
  endtask

  task automatic access(logic [2:0] f, logic [15:0] a, logic [7:0] d);
    item_t it;
    it.func = func_t'(f);
    it.addr = a;
    it.wdata = d;
    it.player_one = 8'($urandom);
    it.player_two = 8'($urandom);
    it.system_buttons = 8'($urandom);
    it.mix_flag = 1'($urandom);
    it.sprite_flag = 1'($urandom);
    send(it);
  endtask

  // region boundaries of both address maps
  function automatic logic [15:0] boundary_addr(int idx);
    case (idx)
      0: return 16'h0000;   1: return 16'h7FFF;   2: return 16'h8000;
      3: return 16'hBFFF;   4: return 16'hC000;   5: return 16'hCFFF;
      6: return 16'hD000;   7: return 16'hD7FF;   8: return 16'hD800;
      9: return 16'hDFFF;  10: return 16'hE000;  11: return 16'hEFFF;
      12: return 16'hF000; 13: return 16'hF3FF;  14: return 16'hF400;
      15: return 16'hF7FF; 16: return 16'hF800;  17: return 16'hFBFF;
      18: return 16'hFC00; 19: return 16'hFFFF;  20: return 16'h87FF;
      21: return 16'h8800; 22: return 16'hA000;  default: return 16'hBFFF;
    endcase
  endfunction

  task automatic random_access();
    int pick;
    int port_pick;
    logic [2:0] f;
    logic [15:0] a;
    pick = $urandom_range(99);
    if (pick < 3) f = FUNC_UNDEFINED;
    else if (pick < 20) f = FUNC_IO_OUT;
    else if (pick < 32) f = FUNC_IO_IN;
    else begin
      case ($urandom_range(4))
        0: f = FUNC_MAIN_RD;
        1: f = FUNC_MAIN_WR;
        2: f = FUNC_MAIN_FE;
        3: f = FUNC_SND_RD;
        default: f = FUNC_SND_WR;
      endcase
    end
    a = 16'($urandom);
    if (f == FUNC_IO_IN || f == FUNC_IO_OUT) begin
      // mostly the latch ports, sometimes any port
      port_pick = $urandom_range(99);
      if (port_pick < 45) a[4:0] = PORT_SOUND_CMD + 5'($urandom_range(3));
      else if (port_pick < 85) a[4:0] = 5'($urandom_range(23));
    end else if ($urandom_range(1) == 0) begin
      a = boundary_addr($urandom_range(23));
    end
    access(f, a, 8'($urandom));
  endtask

  // setup and access cycle, then the bus goes idle
  task automatic dsw_write(logic idx, logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_switch(idx, val);
    @(posedge clk);
  endtask

  // let every expected decode come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending_decodes.size() != 0) @(posedge clk);
  endtask

  initial begin
    board = new(VRAM_BYTES);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: map edges, banking, collisions, ports and sound space
    access(FUNC_MAIN_RD, 16'h0000, 8'h00);
    access(FUNC_MAIN_WR, 16'h0000, 8'hFF);          // rom write ignored
    access(FUNC_IO_IN, 16'h000C, 8'h00);            // switches at reset
    access(FUNC_IO_OUT, {11'h7FF, PORT_MODE}, 8'h8C); // bank 3, flip
    access(FUNC_MAIN_RD, 16'h8000, 8'h00);
    access(FUNC_MAIN_FE, 16'hBFFF, 8'h00);
    access(FUNC_MAIN_FE, 16'h7FFF, 8'h00);
    access(FUNC_MAIN_FE, 16'hC000, 8'h00);          // fetch above rom
    access(FUNC_IO_OUT, {11'h0, PORT_C}, 8'h06);    // video bank 3
    access(FUNC_MAIN_RD, 16'hE000, 8'h00);
    access(FUNC_MAIN_WR, 16'hEFFF, 8'hA5);
    access(FUNC_MAIN_RD, 16'hF03F, 8'h00);
    access(FUNC_MAIN_RD, 16'hFBFF, 8'h00);
    access(FUNC_MAIN_RD, 16'hF400, 8'h00);          // reset space read
    access(FUNC_MAIN_WR, 16'hF7FF, 8'hFF);          // summary clears
    access(FUNC_MAIN_WR, 16'hFFFF, 8'hFF);
    access(FUNC_IO_OUT, {11'h0, PORT_CONTROL}, 8'h0F);
    access(FUNC_IO_OUT, {11'h0, PORT_CONTROL}, 8'h80); // mode set ignored
    access(FUNC_IO_IN, {11'h0, PORT_C}, 8'h00);
    access(FUNC_IO_OUT, {11'h0, PORT_SOUND_CMD}, 8'h5A);
    access(FUNC_SND_RD, 16'hE000, 8'h00);           // latch read, ack bit
    access(FUNC_SND_RD, 16'h9000, 8'h00);
    access(FUNC_SND_WR, 16'hA000, 8'h33);
    access(FUNC_SND_WR, 16'hC7FF, 8'hFF);
    access(FUNC_IO_IN, 16'hFFFF, 8'h00);            // unlisted port
    access(FUNC_UNDEFINED, 16'h1234, 8'h00);
    drain();

    // random phases, each under its own switch setting
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin dsw_write(CFG_DSW_A, 8'h00); dsw_write(CFG_DSW_B, 8'hFF); end
        1: begin dsw_write(CFG_DSW_A, 8'hFF); dsw_write(CFG_DSW_B, 8'h00); end
        2: begin dsw_write(CFG_DSW_A, 8'hA5); dsw_write(CFG_DSW_B, 8'h5A); end
        default: begin
          dsw_write(CFG_DSW_A, 8'($urandom));
          dsw_write(CFG_DSW_B, 8'($urandom));
        end
      endcase
      calm = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) random_access();
      drain();
      calm = 1'b0;
    end

    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending_decodes.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
